// ===== design/rgbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbs_pkg
// Shared sizes, register indexes, kernel constants and helpers of the
// 3x3 RGB sharpening stream.
// ----------------------------------------------------------------------------
package rgbs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE   = 3;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam int CH_W   = 8;
	localparam int NUM_CH = 3;
	localparam int PIX_W  = NUM_CH * CH_W;

	localparam int CFG_W_W    = 11;
	localparam int CFG_H_W    = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int H_W    = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SLOT_W = $clog2(2 * MAX_WIDTH);
	localparam int RING_W = SLOT_W + 1;
	localparam int DEPTH  = 2 * MAX_WIDTH;
	localparam int STEP_W = $clog2(CNT_W + 1);

	localparam int KERNEL_CENTER = 5;
	localparam int CHAN_MAX      = 255;
	localparam int SUM_W         = 12;

	localparam int NUM_RD = 4;
	localparam int RD_C   = 0;
	localparam int RD_U   = 1;
	localparam int RD_L   = 2;
	localparam int RD_R   = 3;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_status_t;

	function automatic logic [W_W-1:0] clamp_width(input logic [CFG_W_W-1:0] v);
		int x;
		x = int'(v);
		if (x < MIN_SIZE) begin
			x = MIN_SIZE;
		end else if (x > MAX_WIDTH) begin
			x = MAX_WIDTH;
		end
		return W_W'(x);
	endfunction

	function automatic logic [H_W-1:0] clamp_height(input logic [CFG_H_W-1:0] v);
		int x;
		x = int'(v);
		if (x < MIN_SIZE) begin
			x = MIN_SIZE;
		end else if (x > MAX_HEIGHT) begin
			x = MAX_HEIGHT;
		end
		return H_W'(x);
	endfunction

endpackage

// ===== design/rgbs_lane.sv =====
// ----------------------------------------------------------------------------
// rgbs_lane
// One colour channel of the cross kernel: 5*centre minus four neighbours,
// clamped to the channel range, or the centre copied at borders and drains.
// ----------------------------------------------------------------------------
module rgbs_lane (
	input  logic                      copy,
	input  logic [rgbs_pkg::CH_W-1:0] center,
	input  logic [rgbs_pkg::CH_W-1:0] up,
	input  logic [rgbs_pkg::CH_W-1:0] down,
	input  logic [rgbs_pkg::CH_W-1:0] left,
	input  logic [rgbs_pkg::CH_W-1:0] right,
	output logic [rgbs_pkg::CH_W-1:0] result
);

	logic [rgbs_pkg::SUM_W-2:0]        pos;
	logic [rgbs_pkg::SUM_W-3:0]        neg;
	logic signed [rgbs_pkg::SUM_W-1:0] sum;
	logic [rgbs_pkg::CH_W-1:0]         clamped;

	always_comb begin
		pos = (rgbs_pkg::SUM_W-1)'(center) * (rgbs_pkg::SUM_W-1)'(rgbs_pkg::KERNEL_CENTER);
		neg = (rgbs_pkg::SUM_W-2)'(up) + (rgbs_pkg::SUM_W-2)'(down)
			+ (rgbs_pkg::SUM_W-2)'(left) + (rgbs_pkg::SUM_W-2)'(right);
		sum = $signed({1'b0, pos}) - $signed({2'b00, neg});
		if (sum <= 0) begin
			clamped = '0;
		end else if (sum >= rgbs_pkg::SUM_W'(rgbs_pkg::CHAN_MAX)) begin
			clamped = rgbs_pkg::CH_W'(rgbs_pkg::CHAN_MAX);
		end else begin
			clamped = sum[rgbs_pkg::CH_W-1:0];
		end
		result = copy ? center : clamped;
	end

endmodule

// ===== design/rgbs_mod.sv =====
// ----------------------------------------------------------------------------
// rgbs_mod
// Restoring remainder unit, one dividend bit per cycle; rebuilds a ring
// slot from a pixel count after the image width or height is written.
// ----------------------------------------------------------------------------
module rgbs_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rgbs_pkg::CNT_W-1:0]  dividend,
	input  logic [rgbs_pkg::RING_W-1:0] divisor,
	output rgbs_pkg::mod_status_t       status,
	output logic [rgbs_pkg::RING_W-1:0] remainder
);

	logic [rgbs_pkg::CNT_W-1:0]  shift_q;
	logic [rgbs_pkg::RING_W-1:0] rem_q;
	logic [rgbs_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rgbs_pkg::RING_W:0]   trial;
	logic [rgbs_pkg::RING_W:0]   reduced;

	always_comb begin
		trial   = {rem_q, shift_q[rgbs_pkg::CNT_W-1]};
		reduced = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= rgbs_pkg::STEP_W'(rgbs_pkg::CNT_W);
		end else if (busy_q && !done_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == rgbs_pkg::STEP_W'(1)) begin
				done_q <= 1'b1;
			end
		end else if (done_q) begin
			done_q <= 1'b0;
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q && !done_q) begin
			shift_q <= shift_q << 1;
			rem_q   <= reduced[rgbs_pkg::RING_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

// ===== design/rgbs_history.sv =====
// ----------------------------------------------------------------------------
// rgbs_history
// Two-row pixel ring, held in two identical copies so that four window
// taps can be read per item; one shared write, registered reads.
// ----------------------------------------------------------------------------
module rgbs_history (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rgbs_pkg::SLOT_W-1:0] waddr,
	input  logic [rgbs_pkg::PIX_W-1:0]  wdata,
	input  logic                        re,
	input  logic [rgbs_pkg::SLOT_W-1:0] raddr [rgbs_pkg::NUM_RD],
	output logic [rgbs_pkg::PIX_W-1:0]  rdata [rgbs_pkg::NUM_RD]
);

	logic [rgbs_pkg::PIX_W-1:0] bank0 [rgbs_pkg::DEPTH];
	logic [rgbs_pkg::PIX_W-1:0] bank1 [rgbs_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			bank0[waddr] <= wdata;
		end
		if (re) begin
			rdata[rgbs_pkg::RD_C] <= bank0[raddr[rgbs_pkg::RD_C]];
			rdata[rgbs_pkg::RD_U] <= bank0[raddr[rgbs_pkg::RD_U]];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			bank1[waddr] <= wdata;
		end
		if (re) begin
			rdata[rgbs_pkg::RD_L] <= bank1[raddr[rgbs_pkg::RD_L]];
			rdata[rgbs_pkg::RD_R] <= bank1[raddr[rgbs_pkg::RD_R]];
		end
	end

endmodule

// ===== design/rgb_sharpen_3x3_stream.sv =====
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_stream
// Cross-kernel sharpening of a raster RGB stream, one lane per colour,
// border pixels copied, results one row behind the input.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: red, green, blue; tuser: opcode
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: red, green, blue; tlast: frame_end
//  cfg       in         cfg_we                        cfg_index, cfg_data
//
// one item per clock unless a rebuild or a stalled output holds the input, the four
// window taps come from the registered reads of a duplicated two-row ring; a result
// passes the window stage and then the output register; a register write holds
// s_axis_tready low while the ring slots are rebuilt bit by bit from the pixel counts
// reset clears counters and loads the default sizes at once; the ring needs no clearing
// a stalled output register stalls the window stage and then the input
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_stream (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rgbs_pkg::PIX_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
	input  logic [0:0]                      s_axis_tuser,  // opcode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rgbs_pkg::PIX_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [rgbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbs_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [rgbs_pkg::W_W-1:0]    w_q;
	logic [rgbs_pkg::H_W-1:0]    h_q;
	logic [rgbs_pkg::CNT_W-1:0]  total_q;
	logic                        start_q;
	logic [rgbs_pkg::CNT_W-1:0]  in_count_q;
	logic [rgbs_pkg::CNT_W-1:0]  out_count_q;
	logic [rgbs_pkg::SLOT_W-1:0] in_slot_q;
	logic [rgbs_pkg::SLOT_W-1:0] out_slot_q;
	logic [rgbs_pkg::W_W-1:0]    col_q;
	logic [rgbs_pkg::CNT_W-1:0]  row_q;

	logic                        valid_s1;
	logic                        copy_s1;
	logic                        last_s1;
	logic [rgbs_pkg::PIX_W-1:0]  d_s1;

	logic                        m_valid_q;
	logic                        m_last_q;
	logic [rgbs_pkg::PIX_W-1:0]  m_data_q;

	logic [rgbs_pkg::RING_W-1:0] ring;
	logic [rgbs_pkg::RING_W-1:0] w_ring;
	logic [rgbs_pkg::RING_W-1:0] os_ext;
	logic [rgbs_pkg::RING_W-1:0] is_ext;
	logic [rgbs_pkg::RING_W-1:0] r_sum;
	logic [rgbs_pkg::RING_W-1:0] u_sum;
	logic [rgbs_pkg::RING_W-1:0] i_sum;
	logic [rgbs_pkg::RING_W-1:0] a_r;
	logic [rgbs_pkg::RING_W-1:0] a_l;
	logic [rgbs_pkg::RING_W-1:0] a_u;
	logic [rgbs_pkg::RING_W-1:0] in_next;
	logic [rgbs_pkg::CNT_W-1:0]  w_ext;
	logic [rgbs_pkg::CNT_W-1:0]  h_ext;

	logic in_full;
	logic out_open;
	logic px_item;
	logic emit_drain;
	logic emit_px;
	logic emit;
	logic border;
	logic frame_last;
	logic accept;
	logic busy;
	logic advance;

	rgbs_pkg::mod_status_t       st_in;
	rgbs_pkg::mod_status_t       st_out;
	logic [rgbs_pkg::RING_W-1:0] rem_in;
	logic [rgbs_pkg::RING_W-1:0] rem_out;

	logic [rgbs_pkg::SLOT_W-1:0] raddr [rgbs_pkg::NUM_RD];
	logic [rgbs_pkg::PIX_W-1:0]  rdata [rgbs_pkg::NUM_RD];
	logic [rgbs_pkg::PIX_W-1:0]  lane_res;

	always_comb begin
		ring    = rgbs_pkg::RING_W'({w_q, 1'b0});
		w_ring  = rgbs_pkg::RING_W'(w_q);
		os_ext  = rgbs_pkg::RING_W'(out_slot_q);
		is_ext  = rgbs_pkg::RING_W'(in_slot_q);
		r_sum   = os_ext + 1'b1;
		a_r     = (r_sum == ring) ? '0 : r_sum;
		a_l     = (os_ext == '0) ? (ring - 1'b1) : (os_ext - 1'b1);
		u_sum   = os_ext + w_ring;
		a_u     = (u_sum >= ring) ? (u_sum - ring) : u_sum;
		i_sum   = is_ext + 1'b1;
		in_next = (i_sum == ring) ? '0 : i_sum;
		w_ext   = rgbs_pkg::CNT_W'(w_q);
		h_ext   = rgbs_pkg::CNT_W'(h_q);

		raddr[rgbs_pkg::RD_C] = out_slot_q;
		raddr[rgbs_pkg::RD_U] = a_u[rgbs_pkg::SLOT_W-1:0];
		raddr[rgbs_pkg::RD_L] = a_l[rgbs_pkg::SLOT_W-1:0];
		raddr[rgbs_pkg::RD_R] = a_r[rgbs_pkg::SLOT_W-1:0];

		in_full    = in_count_q >= total_q;
		out_open   = out_count_q < total_q;
		px_item    = !s_axis_tuser[0] && !in_full;
		emit_drain = !px_item && in_full && out_open;
		emit_px    = px_item && (in_count_q >= w_ext) && out_open;
		emit       = emit_drain || emit_px;
		border     = (row_q == '0) || (row_q >= (h_ext - 1'b1))
			|| (col_q == '0) || (col_q >= (w_q - 1'b1));
		frame_last = (out_count_q + 1'b1) == total_q;

		busy          = start_q || st_in.busy || st_out.busy;
		advance       = valid_s1 && (!m_valid_q || m_axis_tready);
		s_axis_tready = !busy && (!valid_s1 || advance);
		accept        = s_axis_tvalid && s_axis_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= rgbs_pkg::W_W'(rgbs_pkg::RESET_WIDTH);
			h_q         <= rgbs_pkg::H_W'(rgbs_pkg::RESET_HEIGHT);
			total_q     <= rgbs_pkg::CNT_W'(rgbs_pkg::RESET_WIDTH * rgbs_pkg::RESET_HEIGHT);
			start_q     <= 1'b0;
			in_count_q  <= '0;
			out_count_q <= '0;
			in_slot_q   <= '0;
			out_slot_q  <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else begin
			start_q <= 1'b0;
			total_q <= w_ext * h_ext;
			if (cfg_we) begin
				unique case (cfg_index)
					rgbs_pkg::CFG_IMAGE_WIDTH: begin
						w_q     <= rgbs_pkg::clamp_width(cfg_data[rgbs_pkg::CFG_W_W-1:0]);
						start_q <= 1'b1;
					end
					rgbs_pkg::CFG_IMAGE_HEIGHT: begin
						h_q     <= rgbs_pkg::clamp_height(cfg_data[rgbs_pkg::CFG_H_W-1:0]);
						start_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (st_in.done) begin
				in_slot_q <= rem_in[rgbs_pkg::SLOT_W-1:0];
			end
			if (st_out.done) begin
				out_slot_q <= rem_out[rgbs_pkg::SLOT_W-1:0];
			end
			if (accept) begin
				if (px_item) begin
					in_count_q <= in_count_q + 1'b1;
					in_slot_q  <= in_next[rgbs_pkg::SLOT_W-1:0];
				end
				if (emit) begin
					if (frame_last) begin
						in_count_q  <= '0;
						out_count_q <= '0;
						in_slot_q   <= '0;
						out_slot_q  <= '0;
						col_q       <= '0;
						row_q       <= '0;
					end else begin
						out_count_q <= out_count_q + 1'b1;
						out_slot_q  <= a_r[rgbs_pkg::SLOT_W-1:0];
						if ((col_q + 1'b1) >= w_q) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
			end
		end
	end

	rgbs_mod u_mod_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (in_count_q),
		.divisor   (ring),
		.status    (st_in),
		.remainder (rem_in)
	);

	rgbs_mod u_mod_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (out_count_q),
		.divisor   (ring),
		.status    (st_out),
		.remainder (rem_out)
	);

	rgbs_history u_history (
		.clk   (clk),
		.we    (accept && px_item),
		.waddr (in_slot_q),
		.wdata (s_axis_tdata),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	// window stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			copy_s1 <= emit_drain || border;
			last_s1 <= frame_last;
			d_s1    <= s_axis_tdata;
		end
	end

	for (genvar i = 0; i < rgbs_pkg::NUM_CH; i++) begin : g_lane
		rgbs_lane u_lane (
			.copy   (copy_s1),
			.center (rdata[rgbs_pkg::RD_C][i*rgbs_pkg::CH_W +: rgbs_pkg::CH_W]),
			.up     (rdata[rgbs_pkg::RD_U][i*rgbs_pkg::CH_W +: rgbs_pkg::CH_W]),
			.down   (d_s1[i*rgbs_pkg::CH_W +: rgbs_pkg::CH_W]),
			.left   (rdata[rgbs_pkg::RD_L][i*rgbs_pkg::CH_W +: rgbs_pkg::CH_W]),
			.right  (rdata[rgbs_pkg::RD_R][i*rgbs_pkg::CH_W +: rgbs_pkg::CH_W]),
			.result (lane_res[i*rgbs_pkg::CH_W +: rgbs_pkg::CH_W])
		);
	end

	// merge into output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= lane_res;
			m_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_count_q <= in_count_q)
		else $error("more results counted than pixels taken");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (rgbs_pkg::RING_W'(in_slot_q) < ring && os_ext < ring))
		else $error("ring slot outside the two-row ring");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && frame_last |=> (in_count_q == '0 && out_count_q == '0))
		else $error("counters not cleared after the final item of a frame");

	a_emit_staged: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> valid_s1)
		else $error("result lost between accept and window stage");

endmodule
